// ----- sv/msr_pkg.sv -----
// ----------------------------------------------------------------------------
// msr_pkg
// Shared constants for the modulated reflectance sensor: register indexes,
// register reset values and the fixed-point coefficients of the correction.
// ----------------------------------------------------------------------------
package msr_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_ON_PERIOD      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_PERIOD     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_LENGTH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 2'd3;

	// register and field widths
	localparam int PERIOD_W = 10;
	localparam int TICK_W   = 7;
	localparam int COUNT_W  = 11;
	localparam int LUM_W    = 24;

	// reset values
	localparam logic [PERIOD_W-1:0] ON_PERIOD_RST      = 10'd20;
	localparam logic [PERIOD_W-1:0] OFF_PERIOD_RST     = 10'd20;
	localparam logic [TICK_W-1:0]   TICK_LENGTH_RST    = 7'd4;
	localparam logic [LUM_W-1:0]    LINE_THRESHOLD_RST = 24'd26644;

	// correction k = (a*d - b)*d + c, coefficients in unsigned Q.32
	localparam int COEF_A_W = 23;
	localparam int COEF_B_W = 32;
	localparam int COEF_C_W = 39;
	localparam logic [COEF_A_W-1:0] COEF_A = 23'd4459035;
	localparam logic [COEF_B_W-1:0] COEF_B = 32'd2718499550;
	localparam logic [COEF_C_W-1:0] COEF_C = 39'd473477194711;

	// Q.32 to Q.16 conversion
	localparam int FRAC_DROP = 16;
	localparam int LUM_SHIFT = 8;     // diff*2^32 / k >= 2^24  <=>  diff*2^8 >= k

endpackage

// ----- sv/msr_if.sv -----
// ----------------------------------------------------------------------------
// msr_in_if / msr_out_if
// Valid/ready channels of the sensor: raw samples in, measurement beats out.
// ----------------------------------------------------------------------------
interface msr_in_if #(
	parameter int SAMPLE_BITS = 10
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] light_sample;

	modport source (output valid, output light_sample, input ready);
	modport sink   (input valid, input light_sample, output ready);
endinterface

interface msr_out_if ();
	logic        valid;
	logic        ready;
	logic [23:0] luminance;
	logic        new_measurement;
	logic        on_line;
	logic        lamp_on;

	modport source (output valid, output luminance, output new_measurement,
		output on_line, output lamp_on, input ready);
	modport sink   (input valid, input luminance, input new_measurement,
		input on_line, input lamp_on, output ready);
endinterface

// ----- sv/msr_kcalc.sv -----
// ----------------------------------------------------------------------------
// msr_kcalc
// Bit-serial evaluation of the correction k = (a*d - b)*d + c in Q.32,
// rounded to Q.16 and clamped to at least one LSB.
// ----------------------------------------------------------------------------
module msr_kcalc
	import msr_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [SAMPLE_BITS-1:0]    dark,
	output logic [2*SAMPLE_BITS+10:0] k16,
	output logic                      done
);

	localparam int MW = SAMPLE_BITS + 26;          // a*d - b, two's complement
	localparam int PW = MW + SAMPLE_BITS + 1;      // k in Q.32, two's complement
	localparam int KW = PW - FRAC_DROP;            // k in Q.16
	localparam int CW = $clog2(SAMPLE_BITS + 1);

	localparam logic [2:0] K_IDLE = 3'd0;
	localparam logic [2:0] K_MUL1 = 3'd1;
	localparam logic [2:0] K_SUBB = 3'd2;
	localparam logic [2:0] K_MUL2 = 3'd3;
	localparam logic [2:0] K_ADDC = 3'd4;
	localparam logic [2:0] K_RND  = 3'd5;

	logic [2:0]             state_q;
	logic [CW-1:0]          cnt_q;
	logic [SAMPLE_BITS-1:0] d_q;
	logic [SAMPLE_BITS-1:0] dsh_q;
	logic [PW-1:0]          acc_q;
	logic [MW-1:0]          m_q;
	logic [KW-1:0]          k16_q;
	logic                   done_q;

	logic [PW-1:0] addend;
	logic [PW-1:0] acc_dbl;
	logic [PW-1:0] rnd;
	logic [KW-1:0] kv;

	// msb-first shift-add: acc = 2*acc + bit*multiplicand
	always_comb begin
		if (state_q == K_MUL2) begin
			addend = {{(PW-MW){m_q[MW-1]}}, m_q};
		end else begin
			addend = {{(PW-COEF_A_W){1'b0}}, COEF_A};
		end
		acc_dbl = {acc_q[PW-2:0], 1'b0} + (dsh_q[SAMPLE_BITS-1] ? addend : '0);
		rnd     = acc_q + PW'(32768);
		kv      = rnd[PW-1:FRAC_DROP];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= K_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				K_IDLE: begin
					if (start) begin
						state_q <= K_MUL1;
						cnt_q   <= CW'(SAMPLE_BITS);
					end
				end
				K_MUL1: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= K_SUBB;
					end
				end
				K_SUBB: begin
					state_q <= K_MUL2;
					cnt_q   <= CW'(SAMPLE_BITS);
				end
				K_MUL2: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= K_ADDC;
					end
				end
				K_ADDC: begin
					state_q <= K_RND;
				end
				K_RND: begin
					state_q <= K_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= K_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			K_IDLE: begin
				if (start) begin
					d_q   <= dark;
					dsh_q <= dark;
					acc_q <= '0;
				end
			end
			K_MUL1, K_MUL2: begin
				acc_q <= acc_dbl;
				dsh_q <= {dsh_q[SAMPLE_BITS-2:0], 1'b0};
			end
			K_SUBB: begin
				m_q   <= acc_q[MW-1:0] - {{(MW-COEF_B_W){1'b0}}, COEF_B};
				acc_q <= '0;
				dsh_q <= d_q;
			end
			K_ADDC: begin
				acc_q <= acc_q + {{(PW-COEF_C_W){1'b0}}, COEF_C};
			end
			K_RND: begin
				// non-positive k or a rounded zero clamps to one lsb
				if (acc_q[PW-1] || (kv == '0)) begin
					k16_q <= KW'(1);
				end else begin
					k16_q <= kv;
				end
			end
			default: begin
			end
		endcase
	end

	assign k16  = k16_q;
	assign done = done_q;

	a_k_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (k16_q != '0))
		else $error("correction result is zero");

endmodule

// ----- sv/msr_div.sv -----
// ----------------------------------------------------------------------------
// msr_div
// Restoring radix-2 divider: luminance = floor(diff*2^32 / k), one quotient
// bit per cycle, saturated to 24 bits.
// ----------------------------------------------------------------------------
module msr_div
	import msr_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [SAMPLE_BITS-1:0]    diff,
	input  logic [2*SAMPLE_BITS+10:0] k16,
	output logic [LUM_W-1:0]          quot,
	output logic                      done
);

	localparam int KW = 2*SAMPLE_BITS + 11;
	localparam int CW = $clog2(LUM_W + 1);

	logic             run_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [KW-1:0]    k_q;
	logic [KW-1:0]    rem_q;
	logic [LUM_W-1:0] quot_q;

	logic [KW-1:0] num0;
	logic          sat;
	logic [KW:0]   trial;
	logic [KW:0]   rem_dbl;

	always_comb begin
		num0    = {{(KW-SAMPLE_BITS-LUM_SHIFT){1'b0}}, diff, {LUM_SHIFT{1'b0}}};
		sat     = (num0 >= k16);
		rem_dbl = {rem_q, 1'b0};
		trial   = rem_dbl - {1'b0, k_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= CW'(LUM_W);
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q    <= k16;
			rem_q  <= num0;
			quot_q <= sat ? '1 : '0;
		end else if (run_q) begin
			if (!trial[KW]) begin
				rem_q <= trial[KW-1:0];
			end else begin
				rem_q <= rem_dbl[KW-1:0];
			end
			quot_q <= {quot_q[LUM_W-2:0], ~trial[KW]};
		end
	end

	assign quot = quot_q;
	assign done = done_q;

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		(start && sat) |=> (done_q && (quot_q == '1)))
		else $error("saturated quotient not flagged at once");

endmodule

// ----- sv/modulated_reflectance_sensor.sv -----
// ----------------------------------------------------------------------------
// modulated_reflectance_sensor
// Lamp phase sequencer with dark/lit sampling and corrected luminance output.
// ----------------------------------------------------------------------------
// beats: a non-measuring tick gives its beat in the cycle after it is taken; a tick
//   ending a lit phase gives it once the bit-serial k multiply and the 24-step divide
//   are through, or with no divide steps if the quotient saturates
// flow: one tick at a time; a measuring tick holds the input until its beat is
//   written, other ticks can follow back to back while the receiver takes each beat
// reset: registers at their defaults, dark phase, counter at off period, luminance 0
// ----------------------------------------------------------------------------
module modulated_reflectance_sensor
	import msr_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	msr_in_if.sink                sample_ch,
	msr_out_if.source             result_ch
);

	localparam int KW = 2*SAMPLE_BITS + 11;

	// top-level sequencer codes
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_KCALC = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;

	// configuration registers
	logic [PERIOD_W-1:0] on_period_q;
	logic [PERIOD_W-1:0] off_period_q;
	logic [TICK_W-1:0]   tick_length_q;
	logic [LUM_W-1:0]    line_threshold_q;

	// phase and readings
	logic                   phase_lit_q;
	logic [COUNT_W-1:0]     phase_cnt_q;
	logic [SAMPLE_BITS-1:0] lit_q;
	logic [SAMPLE_BITS-1:0] dark_q;
	logic [SAMPLE_BITS-1:0] diff_q;
	logic [1:0]             state_q;

	// output register, lum_q doubles as the held luminance
	logic             out_valid_q;
	logic [LUM_W-1:0] lum_q;
	logic             new_meas_q;
	logic             on_line_q;
	logic             lamp_on_q;

	logic                   accept;
	logic                   drain;
	logic                   expire;
	logic                   launch;
	logic                   phase_next;
	logic [SAMPLE_BITS-1:0] sample;

	logic             kc_done;
	logic [KW-1:0]    k16;
	logic             div_start;
	logic             div_done;
	logic [LUM_W-1:0] quot;

	assign sample = sample_ch.light_sample;

	// take a sample only when idle and the output slot will be free
	assign sample_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || result_ch.ready);
	assign accept          = sample_ch.valid && sample_ch.ready;
	assign drain           = out_valid_q && result_ch.ready;

	// phase ends when the counter would not stay above zero
	assign expire     = (phase_cnt_q <= {{(COUNT_W-TICK_W){1'b0}}, tick_length_q});
	assign launch     = accept && expire && phase_lit_q;
	assign phase_next = expire ? ~phase_lit_q : phase_lit_q;
	assign div_start  = kc_done;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_period_q      <= ON_PERIOD_RST;
			off_period_q     <= OFF_PERIOD_RST;
			tick_length_q    <= TICK_LENGTH_RST;
			line_threshold_q <= LINE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ON_PERIOD:      on_period_q      <= cfg_data[PERIOD_W-1:0];
				REG_OFF_PERIOD:     off_period_q     <= cfg_data[PERIOD_W-1:0];
				REG_TICK_LENGTH:    tick_length_q    <= cfg_data[TICK_W-1:0];
				REG_LINE_THRESHOLD: line_threshold_q <= cfg_data[LUM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// phase sequencer, readings and measurement control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_lit_q <= 1'b0;
			phase_cnt_q <= {{(COUNT_W-PERIOD_W){1'b0}}, OFF_PERIOD_RST};
			lit_q       <= '0;
			dark_q      <= '0;
			state_q     <= ST_IDLE;
		end else begin
			if (accept) begin
				if (phase_lit_q) begin
					lit_q <= sample;
				end else begin
					dark_q <= sample;
				end
				if (!expire) begin
					phase_cnt_q <= phase_cnt_q - {{(COUNT_W-TICK_W){1'b0}}, tick_length_q};
				end else if (phase_lit_q) begin
					phase_lit_q <= 1'b0;
					phase_cnt_q <= {{(COUNT_W-PERIOD_W){1'b0}}, off_period_q};
				end else begin
					phase_lit_q <= 1'b1;
					phase_cnt_q <= {{(COUNT_W-PERIOD_W){1'b0}}, on_period_q};
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (launch) begin
						state_q <= ST_KCALC;
					end
				end
				ST_KCALC: begin
					if (kc_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// clamped difference, lit reading is this tick's sample
	always_ff @(posedge clk) begin
		if (launch) begin
			diff_q <= (dark_q > sample) ? (dark_q - sample) : '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			lum_q       <= '0;
			new_meas_q  <= 1'b0;
			on_line_q   <= 1'b0;
			lamp_on_q   <= 1'b0;
		end else begin
			if (accept && !launch) begin
				out_valid_q <= 1'b1;
				new_meas_q  <= 1'b0;
				on_line_q   <= (lum_q < line_threshold_q);
				lamp_on_q   <= phase_next;
			end else if (div_done) begin
				out_valid_q <= 1'b1;
				lum_q       <= quot;
				new_meas_q  <= 1'b1;
				on_line_q   <= (quot < line_threshold_q);
				lamp_on_q   <= phase_lit_q;
			end else if (drain) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_ch.valid           = out_valid_q;
	assign result_ch.luminance       = lum_q;
	assign result_ch.new_measurement = new_meas_q;
	assign result_ch.on_line         = on_line_q;
	assign result_ch.lamp_on         = lamp_on_q;

	msr_kcalc #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_kcalc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (launch),
		.dark   (dark_q),
		.k16    (k16),
		.done   (kc_done)
	);

	msr_div #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diff   (diff_q),
		.k16    (k16),
		.quot   (quot),
		.done   (div_done)
	);

	a_kc_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		kc_done |-> (state_q == ST_KCALC))
		else $error("correction finished outside a measurement");

	a_meas_beat: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |=> (out_valid_q && new_meas_q && !lamp_on_q))
		else $error("finished measurement not presented as a dark-phase beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!out_valid_q || result_ch.ready))
		else $error("sample taken while a beat is still pending");

endmodule

// ----- tb/tb_modulated_reflectance_sensor.sv -----
// ----------------------------------------------------------------------------
// tb_modulated_reflectance_sensor
// Self-checking bench for the lamp-modulated reflectance sensor. A directed
// table covers reset, extreme readings, both ends of the line threshold and
// the zero-period, zero-step and wide-write corners. Random phases then vary
// the lamp timing and the idle pattern on both channels. Every output beat is
// compared with a cycle-free model of the phase sequencer and the fixed-point
// correction.
// ----------------------------------------------------------------------------
module tb_modulated_reflectance_sensor;
	import msr_pkg::*;

	localparam int SAMPLE_BITS     = 10;
	localparam int HALF_PERIOD     = 5;
	localparam int RESET_CYCLES    = 12;
	localparam int N_DIR           = 36;
	localparam int N_PHASES        = 8;
	localparam int TICKS_PER_PHASE = 50;
	localparam int HOLD_PHASE      = 4;
	localparam int LONG_HOLD       = 400;   // receiver hold-off, fills the block
	localparam int TAIL_CYCLES     = 64;    // longer than a full measurement
	localparam int STALL_LIMIT     = 4000;  // cycles with no beat on either side
	localparam int MAX_REPORTS     = 10;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	// one output beat
	typedef struct packed {
		logic [LUM_W-1:0] luminance;
		logic             new_measurement;
		logic             on_line;
		logic             lamp_on;
	} meas_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_TICK, ROW_TICK_CHK} row_kind_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

	// one row of the directed table; data is the register value or the sample
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		meas_t                 want;
	} dir_row_t;

	// beats that can be typed in directly
	localparam meas_t DARK_QUIET  = '{24'd0, 1'b0, 1'b1, 1'b0};
	localparam meas_t LIT_QUIET   = '{24'd0, 1'b0, 1'b1, 1'b1};
	localparam meas_t ZERO_MEAS   = '{24'd0, 1'b1, 1'b1, 1'b0};
	localparam meas_t LIT_NO_LINE = '{24'd0, 1'b0, 1'b0, 1'b1};
	localparam meas_t NO_WANT     = '0;

	// index field is unused on tick rows
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// after reset: dark phase, counter 20, step 4, four ticks then lamp on
		'{ROW_TICK_CHK, '0, 24'd0,    DARK_QUIET},
		'{ROW_TICK_CHK, '0, 24'd1023, DARK_QUIET},
		'{ROW_TICK_CHK, '0, 24'd0,    DARK_QUIET},
		'{ROW_TICK_CHK, '0, 24'd1023, DARK_QUIET},
		'{ROW_TICK_CHK, '0, 24'd1023, LIT_QUIET},
		// lit phase, last lit reading 0 against dark 1023: largest difference
		'{ROW_TICK_CHK, '0, 24'd1023, LIT_QUIET},
		'{ROW_TICK_CHK, '0, 24'd0,    LIT_QUIET},
		'{ROW_TICK_CHK, '0, 24'd1023, LIT_QUIET},
		'{ROW_TICK_CHK, '0, 24'd0,    LIT_QUIET},
		'{ROW_TICK,     '0, 24'd0,    NO_WANT},
		// shortest periods, step 100, threshold at the top
		'{ROW_CFG, REG_ON_PERIOD,      24'd1,       NO_WANT},
		'{ROW_CFG, REG_OFF_PERIOD,     24'd1,       NO_WANT},
		'{ROW_CFG, REG_TICK_LENGTH,    24'd100,     NO_WANT},
		'{ROW_CFG, REG_LINE_THRESHOLD, 24'hFFFFFF,  NO_WANT},
		// lit brighter than dark clamps the difference to zero
		'{ROW_TICK,     '0, 24'd0,    NO_WANT},
		'{ROW_TICK_CHK, '0, 24'd1023, ZERO_MEAS},
		// equal readings
		'{ROW_TICK_CHK, '0, 24'd512,  LIT_QUIET},
		'{ROW_TICK_CHK, '0, 24'd512,  ZERO_MEAS},
		// threshold zero: never on the line
		'{ROW_CFG, REG_LINE_THRESHOLD, 24'd0,       NO_WANT},
		'{ROW_TICK_CHK, '0, 24'd1023, LIT_NO_LINE},
		'{ROW_TICK,     '0, 24'd0,    NO_WANT},
		// dark reading near the minimum of the correction
		'{ROW_TICK,     '0, 24'd305,  NO_WANT},
		'{ROW_TICK,     '0, 24'd0,    NO_WANT},
		// zero periods, step written with junk above its width
		'{ROW_CFG, REG_ON_PERIOD,      24'd0,       NO_WANT},
		'{ROW_CFG, REG_OFF_PERIOD,     24'd0,       NO_WANT},
		'{ROW_CFG, REG_TICK_LENGTH,    24'hFFFF81,  NO_WANT},
		'{ROW_TICK,     '0, 24'd700,  NO_WANT},
		'{ROW_TICK,     '0, 24'd100,  NO_WANT},
		// zero step with zero counter still toggles every tick
		'{ROW_CFG, REG_TICK_LENGTH,    24'd0,       NO_WANT},
		'{ROW_TICK,     '0, 24'd900,  NO_WANT},
		'{ROW_TICK,     '0, 24'd50,   NO_WANT},
		// zero step with a nonzero period: counter sticks, lamp stays lit
		'{ROW_CFG, REG_ON_PERIOD,      24'hFFFC03,  NO_WANT},
		'{ROW_CFG, REG_OFF_PERIOD,     24'd3,       NO_WANT},
		'{ROW_TICK,     '0, 24'd1000, NO_WANT},
		'{ROW_TICK,     '0, 24'd10,   NO_WANT},
		'{ROW_TICK,     '0, 24'd20,   NO_WANT}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	msr_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	msr_out_if                             result_ch ();

	modulated_reflectance_sensor #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.sample_ch(sample_ch),
		.result_ch(result_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// expected beats, oldest first
	meas_t      pending_meas [$];
	idle_mode_t idle_mode;
	int         hold_reqs = 0;
	int         hold_done = 0;
	int         errors = 0;
	int         ticks_sent = 0;
	int         beats_seen = 0;
	int         fresh_seen = 0;
	int         quiet_cycles = 0;
	meas_t      mon_want;
	meas_t      mon_got;

	// sensor model: registers and state
	logic [PERIOD_W-1:0] m_on;
	logic [PERIOD_W-1:0] m_off;
	logic [TICK_W-1:0]   m_step;
	logic [LUM_W-1:0]    m_thr;
	logic                m_lit;
	logic [COUNT_W-1:0]  m_count;
	sample_t             m_lit_rd;
	sample_t             m_dark_rd;
	logic [LUM_W-1:0]    m_lum;

	function automatic void model_reset();
		m_on      = ON_PERIOD_RST;
		m_off     = OFF_PERIOD_RST;
		m_step    = TICK_LENGTH_RST;
		m_thr     = LINE_THRESHOLD_RST;
		m_lit     = 1'b0;
		m_count   = COUNT_W'(OFF_PERIOD_RST);
		m_lit_rd  = '0;
		m_dark_rd = '0;
		m_lum     = '0;
	endfunction

	// writes keep only the low bits of the data
	function automatic void model_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ON_PERIOD: m_on = data[PERIOD_W-1:0];
			REG_OFF_PERIOD: m_off = data[PERIOD_W-1:0];
			REG_TICK_LENGTH: m_step = data[TICK_W-1:0];
			REG_LINE_THRESHOLD: m_thr = data[LUM_W-1:0];
			default: ;
		endcase
	endfunction

	// (dark - lit) / k, k = (a*d - b)*d + c in Q.32 rounded to Q.16, result Q8.16
	function automatic logic [LUM_W-1:0] corrected_luminance(input sample_t lit,
			input sample_t dark);
		logic [63:0] d;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] k32;
		logic [63:0] k16;
		logic [63:0] diff;
		logic [63:0] q;
		d    = 64'(dark);
		pos  = 64'(COEF_A) * d * d + 64'(COEF_C);
		neg  = 64'(COEF_B) * d;
		k32  = (pos > neg) ? pos - neg : 64'd0;
		k16  = (k32 + 64'd32768) >> FRAC_DROP;
		if (k16 < 64'd1) begin
			k16 = 64'd1;
		end
		diff = (dark > lit) ? 64'(dark) - 64'(lit) : 64'd0;
		q    = (diff << 32) / k16;
		if (q > 64'hFFFFFF) begin
			q = 64'hFFFFFF;
		end
		return q[LUM_W-1:0];
	endfunction

	// one tick of the sensor
	function automatic meas_t model_tick(input sample_t s);
		meas_t b;
		logic  fresh;
		fresh = 1'b0;
		if (m_lit) begin
			m_lit_rd = s;
		end else begin
			m_dark_rd = s;
		end
		if (m_count > COUNT_W'(m_step)) begin
			m_count = m_count - COUNT_W'(m_step);
		end else if (m_lit) begin
			// end of lit phase: new measurement
			m_lit   = 1'b0;
			m_count = COUNT_W'(m_off);
			m_lum   = corrected_luminance(m_lit_rd, m_dark_rd);
			fresh   = 1'b1;
		end else begin
			m_lit   = 1'b1;
			m_count = COUNT_W'(m_on);
		end
		b.luminance       = m_lum;
		b.new_measurement = fresh;
		b.on_line         = (m_lum < m_thr);
		b.lamp_on         = m_lit;
		return b;
	endfunction

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int src_idle_pct();
		case (idle_mode)
			IDLE_SRC: return 85;
			IDLE_BOTH: return 11;
			default: return 0;
		endcase
	endfunction

	function automatic int snk_idle_pct();
		case (idle_mode)
			IDLE_SNK: return 85;
			IDLE_BOTH: return 11;
			default: return 0;
		endcase
	endfunction

	// sometimes set junk above the register width
	function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
			input int w);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		junk = junk << w;
		return chance(25) ? (v | junk) : v;
	endfunction

	// dark ticks mostly bright, lit ticks mostly dim, plus noise and extremes
	function automatic sample_t pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			return r[0] ? '1 : '0;
		end
		if (r < 25) begin
			return sample_t'($urandom);
		end
		return m_lit ? sample_t'($urandom_range(0, 700)) : sample_t'($urandom_range(300, 1023));
	endfunction

	// register write, only while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we   <= 1'b0;
		model_config(idx, data);
	endtask

	// offer one sample, return at the edge that takes it
	task automatic send_tick(input sample_t s);
		@(negedge clk);
		while (chance(src_idle_pct())) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.light_sample <= s;
		@(posedge clk);
		while (sample_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		ticks_sent++;
	endtask

	// sender pauses until every expected beat is back
	task automatic drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending_meas.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// lamp timing and threshold for one random phase
	task automatic program_phase(input int p);
		logic [PERIOD_W-1:0] on_len;
		logic [PERIOD_W-1:0] off_len;
		logic [TICK_W-1:0]   step;
		logic [LUM_W-1:0]    thr;
		int                  span;
		if (p == 0) begin
			// periods of 1000 with a step of 100
			on_len  = 10'd1000;
			off_len = 10'd1000;
			step    = 7'd100;
			thr     = 24'hFFFFFF;
		end else if (p == 1) begin
			// lamp toggles every tick
			on_len  = 10'd1;
			off_len = 10'd1;
			step    = 7'd1;
			thr     = 24'd0;
		end else begin
			// keep phases a few ticks long so measurements stay frequent
			step    = TICK_W'($urandom_range(1, 100));
			span    = (int'(step) * 6 > 1000) ? 1000 : int'(step) * 6;
			on_len  = PERIOD_W'($urandom_range(1, span));
			off_len = PERIOD_W'($urandom_range(1, span));
			case ($urandom_range(0, 3))
				0: thr = 24'd0;
				1: thr = 24'hFFFFFF;
				default: thr = LUM_W'($urandom_range(0, 24'h4FFFFF));
			endcase
		end
		write_reg(REG_ON_PERIOD, with_junk(CFG_DATA_W'(on_len), PERIOD_W));
		write_reg(REG_OFF_PERIOD, with_junk(CFG_DATA_W'(off_len), PERIOD_W));
		write_reg(REG_TICK_LENGTH, with_junk(CFG_DATA_W'(step), TICK_W));
		write_reg(REG_LINE_THRESHOLD, CFG_DATA_W'(thr));
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : sink_side
		int hold_left;
		hold_left       = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_done < hold_reqs) begin
				hold_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !chance(snk_idle_pct());
			end
		end
	end

	// checker: each output beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			beats_seen++;
			mon_got = '{result_ch.luminance, result_ch.new_measurement,
				result_ch.on_line, result_ch.lamp_on};
			if (mon_got.new_measurement === 1'b1) begin
				fresh_seen++;
			end
			if (pending_meas.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("unexpected beat: lum %h new %b line %b lamp %b",
						mon_got.luminance, mon_got.new_measurement,
						mon_got.on_line, mon_got.lamp_on);
				end
			end else begin
				mon_want = pending_meas.pop_front();
				if (mon_got.luminance !== mon_want.luminance
						|| mon_got.new_measurement !== mon_want.new_measurement
						|| mon_got.on_line !== mon_want.on_line
						|| mon_got.lamp_on !== mon_want.lamp_on) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("beat %0d: expected lum/new/line/lamp %h %b %b %b",
							beats_seen, mon_want.luminance, mon_want.new_measurement,
							mon_want.on_line, mon_want.lamp_on);
						$display("  got %h %b %b %b", mon_got.luminance,
							mon_got.new_measurement, mon_got.on_line, mon_got.lamp_on);
					end
				end
			end
		end
	end

	// watchdog: no beat on either channel for too long
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
					|| (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d beats outstanding",
					quiet_cycles, pending_meas.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		dir_row_t row;
		meas_t    predicted;
		sample_t  s;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_idx                = '0;
		cfg_data               = '0;
		sample_ch.valid        = 1'b0;
		sample_ch.light_sample = '0;
		idle_mode              = IDLE_NONE;
		model_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, typed-in beats where they are obvious
		for (int i = 0; i < N_DIR; i++) begin
			row = DIR_ROWS[i];
			if (row.kind == ROW_CFG) begin
				drain();
				write_reg(row.idx, row.data);
			end else begin
				send_tick(row.data[SAMPLE_BITS-1:0]);
				predicted = model_tick(row.data[SAMPLE_BITS-1:0]);
				pending_meas.push_back(row.kind == ROW_TICK_CHK ? row.want : predicted);
			end
		end

		// random phases: new timing each phase, idle pattern cycles through all modes
		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			idle_mode = idle_mode_t'(p % 4);
			program_phase(p);
			if (p == HOLD_PHASE) begin
				// receiver holds off while the sender keeps offering
				hold_reqs++;
			end
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				s = pick_sample();
				send_tick(s);
				pending_meas.push_back(model_tick(s));
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		errors += pending_meas.size();
		$display("covered %0d ticks over %0d random phases and the directed table", ticks_sent,
			N_PHASES);
		$display("checked %0d beats, %0d new measurements, %0d mismatches", beats_seen,
			fresh_seen, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
